// ===== rtl/opv_pkg.sv =====
// shared types and constants for the osc packet validator
// no dependencies
`default_nettype none
package opv_pkg;
    localparam int MAX_TAGS_DEF = 16;
    localparam int MAX_PACKET_BYTES_DEF = 4096;
    localparam int HEADER_BYTES = 20;
    localparam int POS_W = 17;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_FIRST, PH_HEADER, PH_ADDR, PH_TAGSTART, PH_TAGS, PH_ARGS, PH_DONE, PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        TC_I, TC_F, TC_S, TC_T, TC_TRUE, TC_FALSE, TC_BAD
    } tag_code_t;

    typedef enum logic [2:0] {
        RG_HEADER = 3'd0, RG_ADDR = 3'd1, RG_TAGS = 3'd2, RG_ARG = 3'd3, RG_STATUS = 3'd4
    } region_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_MALFORMED = 2'd1, ST_TOO_MANY = 2'd2, ST_TOO_LONG = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE, OP_PASS, OP_NUMERIC
    } op_t;

    // command from front to back
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [2:0]  region;
        logic        long_arg;
        logic        close;
        logic [1:0]  status;
    } cmd_t;

    function automatic tag_code_t tag_code(input logic [7:0] b);
        case (b)
            8'h69:   return TC_I;
            8'h66:   return TC_F;
            8'h73:   return TC_S;
            8'h74:   return TC_T;
            8'h54:   return TC_TRUE;
            8'h46:   return TC_FALSE;
            default: return TC_BAD;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/opv_stream_if.sv =====
// valid/ready channel carrying a payload of parameterized width
// no dependencies
`default_nettype none
interface opv_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/opv_front.sv =====
// front: parses packet bytes and issues commands to the back end
// depends on opv_pkg
`default_nettype none
module opv_front
    import opv_pkg::*;
#(
    parameter int MAX_TAGS = MAX_TAGS_DEF,
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic [7:0] in_data,
    input  wire logic in_last,
    output logic      cmd_valid,
    output cmd_t      cmd,
    input  wire logic cmd_room
);
    localparam int TW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int CW = $clog2(MAX_TAGS + 1);

    phase_t         phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]  total_reg, total_next;
    logic [CW-1:0]  ntag_reg, ntag_next;
    logic [CW-1:0]  cursor_reg, cursor_next;
    logic [3:0]     fill_reg, fill_next;
    logic           pad_reg, pad_next;
    logic [1:0]     err_reg, err_next;
    tag_code_t      tags_mem [MAX_TAGS];
    tag_code_t      cur_code_reg, cur_code_next;
    logic           tag_we;
    logic           take;
    logic           aligned_end;
    tag_code_t      code_in;

    assign in_ready = cmd_room;
    assign take = in_valid && cmd_room;
    assign aligned_end = pos_reg[1:0] == 2'd3;
    assign code_in = tag_code(in_data);

    // lookahead for the code at the next cursor, skipping true and false tags
    // tags are resolved on write: store only byte-carrying tags in order
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tags_mem[total_reg[TW-1:0]] <= code_in;
        end
    end

    logic [CW-1:0] cur_inc;
    assign cur_inc = cursor_reg + CW'(1);
    tag_code_t next_code;
    assign next_code = (cur_inc < total_reg) ? tags_mem[cur_inc[TW-1:0]] : TC_BAD;

    always_comb
    begin
        logic s_done;
        logic s_bad;
        phase_next = phase_reg;
        pos_next = pos_reg;
        total_next = total_reg;
        ntag_next = ntag_reg;
        cursor_next = cursor_reg;
        fill_next = fill_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        cur_code_next = cur_code_reg;
        tag_we = 1'b0;
        cmd = '0;
        cmd.op = OP_NONE;
        s_bad = pad_reg && (in_data != 8'd0);
        s_done = !s_bad && (pad_reg || in_data == 8'd0) && aligned_end;
        if (phase_reg != PH_ERROR)
        begin
            if (pos_reg >= POS_W'(MAX_PACKET_BYTES))
            begin
                phase_next = PH_ERROR;
                err_next = ST_TOO_LONG;
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (in_data == 8'h23)
                        begin
                            cmd.op = OP_PASS;
                            cmd.region = RG_HEADER;
                            phase_next = PH_HEADER;
                        end
                        else if (in_data == 8'h2f)
                        begin
                            cmd.op = OP_PASS;
                            cmd.region = RG_ADDR;
                            pad_next = 1'b0;
                            phase_next = PH_ADDR;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            err_next = ST_MALFORMED;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (pos_reg < POS_W'(HEADER_BYTES))
                        begin
                            cmd.op = OP_PASS;
                            cmd.region = RG_HEADER;
                        end
                        else if (in_data == 8'h2f)
                        begin
                            cmd.op = OP_PASS;
                            cmd.region = RG_ADDR;
                            pad_next = 1'b0;
                            phase_next = PH_ADDR;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            err_next = ST_MALFORMED;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (s_bad)
                        begin
                            phase_next = PH_ERROR;
                            err_next = ST_MALFORMED;
                        end
                        else
                        begin
                            cmd.op = OP_PASS;
                            cmd.region = RG_ADDR;
                            if (in_data == 8'd0)
                            begin
                                pad_next = 1'b1;
                            end
                            if (s_done)
                            begin
                                phase_next = PH_TAGSTART;
                            end
                        end
                    end
                    PH_TAGSTART:
                    begin
                        if (in_data != 8'h2c)
                        begin
                            phase_next = PH_ERROR;
                            err_next = ST_MALFORMED;
                        end
                        else
                        begin
                            cmd.op = OP_PASS;
                            cmd.region = RG_TAGS;
                            pad_next = 1'b0;
                            total_next = '0;
                            ntag_next = '0;
                            phase_next = PH_TAGS;
                        end
                    end
                    PH_TAGS:
                    begin
                        if (!pad_reg && in_data != 8'd0)
                        begin
                            if (code_in == TC_BAD)
                            begin
                                phase_next = PH_ERROR;
                                err_next = ST_MALFORMED;
                            end
                            else if (ntag_reg >= CW'(MAX_TAGS))
                            begin
                                phase_next = PH_ERROR;
                                err_next = ST_TOO_MANY;
                            end
                            else
                            begin
                                ntag_next = ntag_reg + CW'(1);
                                cmd.op = OP_PASS;
                                cmd.region = RG_TAGS;
                                if (code_in != TC_TRUE && code_in != TC_FALSE)
                                begin
                                    tag_we = 1'b1;
                                    total_next = total_reg + CW'(1);
                                end
                            end
                        end
                        else if (s_bad)
                        begin
                            phase_next = PH_ERROR;
                            err_next = ST_MALFORMED;
                        end
                        else
                        begin
                            cmd.op = OP_PASS;
                            cmd.region = RG_TAGS;
                            pad_next = 1'b1;
                            if (s_done)
                            begin
                                cursor_next = '0;
                                fill_next = '0;
                                pad_next = 1'b0;
                                cur_code_next = (total_reg != '0) ? tags_mem[0] : TC_BAD;
                                phase_next = (total_reg != '0) ? PH_ARGS : PH_DONE;
                            end
                        end
                    end
                    PH_ARGS:
                    begin
                        if (cur_code_reg == TC_S)
                        begin
                            if (s_bad)
                            begin
                                phase_next = PH_ERROR;
                                err_next = ST_MALFORMED;
                            end
                            else
                            begin
                                cmd.op = OP_PASS;
                                cmd.region = RG_ARG;
                                if (in_data == 8'd0)
                                begin
                                    pad_next = 1'b1;
                                end
                                if (s_done)
                                begin
                                    cursor_next = cur_inc;
                                    pad_next = 1'b0;
                                    fill_next = '0;
                                    cur_code_next = next_code;
                                    phase_next = (cur_inc < total_reg) ? PH_ARGS : PH_DONE;
                                end
                            end
                        end
                        else
                        begin
                            cmd.op = OP_NUMERIC;
                            cmd.region = RG_ARG;
                            cmd.long_arg = cur_code_reg == TC_T;
                            fill_next = fill_reg + 4'd1;
                            if ((cur_code_reg == TC_T) ? (fill_reg == 4'd7) : (fill_reg == 4'd3))
                            begin
                                cmd.close = 1'b1;
                                cursor_next = cur_inc;
                                fill_next = '0;
                                pad_next = 1'b0;
                                cur_code_next = next_code;
                                phase_next = (cur_inc < total_reg) ? PH_ARGS : PH_DONE;
                            end
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_ERROR;
                        err_next = ST_MALFORMED;
                    end
                    default:
                    begin
                    end
                endcase
                if (phase_next != PH_ERROR)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
        cmd.data = in_data;
        if (phase_next == PH_ERROR)
        begin
            cmd.op = OP_NONE;
        end
        if (in_last)
        begin
            cmd.status = (phase_next != PH_ERROR && phase_next != PH_DONE) ?
                         2'(ST_MALFORMED) : err_next;
            phase_next = PH_FIRST;
            pos_next = '0;
            total_next = '0;
            ntag_next = '0;
            cursor_next = '0;
            fill_next = '0;
            pad_next = 1'b0;
            err_next = '0;
        end
    end

    // status rides along on the last command as a separate flag
    logic last_flag;
    assign last_flag = in_last;
    assign cmd_valid = take && (cmd.op != OP_NONE || last_flag);

    // the back end takes the last-byte flag straight from the input channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            pos_reg <= '0;
            total_reg <= '0;
            ntag_reg <= '0;
            cursor_reg <= '0;
            fill_reg <= '0;
            pad_reg <= 1'b0;
            err_reg <= '0;
            cur_code_reg <= TC_BAD;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            total_reg <= total_next;
            ntag_reg <= ntag_next;
            cursor_reg <= cursor_next;
            fill_reg <= fill_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
            cur_code_reg <= cur_code_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/opv_back.sv =====
// back end: queue of commands, numeric reversal, output serialization
// depends on opv_pkg
`default_nettype none
module opv_back
    import opv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    input  wire logic cmd_last,
    output logic      cmd_room,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] region,
    output logic [1:0] status,
    output logic       final_res
);
    localparam int QW = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        cmd_t c;
        logic last;
    } qent_t;

    qent_t          q_mem [QUEUE_DEPTH];
    logic [QW-1:0]  wp_reg, rp_reg;
    logic [QW:0]    cnt_reg;
    logic [7:0]     arg_mem [8];
    logic [2:0]     afill_reg;
    logic [3:0]     drain_reg;
    logic           stat_pend_reg;
    logic [1:0]     stat_reg;
    logic           pass_pend_reg;
    logic [7:0]     pass_byte_reg;
    logic [2:0]     pass_reg_reg;
    logic           busy;
    logic           finishing;
    logic           pop;
    qent_t          head;

    // accept only while the queue can take the item even if the back is busy
    assign cmd_room = cnt_reg < (QW+1)'(QUEUE_DEPTH - 1);
    assign head = q_mem[rp_reg];
    assign busy = drain_reg != '0 || pass_pend_reg || stat_pend_reg;

    // last pending output item leaves this cycle
    assign finishing = out_valid && out_ready &&
                       ((pass_pend_reg && drain_reg == '0 && !stat_pend_reg) ||
                        (!pass_pend_reg && drain_reg == 4'd1 && !stat_pend_reg) ||
                        (!pass_pend_reg && drain_reg == '0 && stat_pend_reg));
    assign pop = cnt_reg != '0 && (!busy || finishing);

    always_comb
    begin
        out_valid = 1'b0;
        out_byte = '0;
        region = '0;
        status = '0;
        final_res = 1'b0;
        if (pass_pend_reg)
        begin
            out_valid = 1'b1;
            out_byte = pass_byte_reg;
            region = pass_reg_reg;
        end
        else if (drain_reg != '0)
        begin
            out_valid = 1'b1;
            out_byte = arg_mem[3'(drain_reg - 4'd1)];
            region = RG_ARG;
        end
        else if (stat_pend_reg)
        begin
            out_valid = 1'b1;
            region = RG_STATUS;
            status = stat_reg;
            final_res = 1'b1;
        end
    end

    logic push;
    assign push = cmd_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= '{c: cmd, last: cmd_last};
        end
        if (pop && head.c.op == OP_NUMERIC)
        begin
            arg_mem[afill_reg] <= head.c.data;
        end
        if (pop)
        begin
            pass_byte_reg <= head.c.data;
            pass_reg_reg <= head.c.region;
            stat_reg <= head.c.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            afill_reg <= '0;
            drain_reg <= '0;
            stat_pend_reg <= 1'b0;
            pass_pend_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + QW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + QW'(1);
            end
            cnt_reg <= cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
            if (out_valid && out_ready)
            begin
                if (pass_pend_reg)
                begin
                    pass_pend_reg <= 1'b0;
                end
                else if (drain_reg != '0)
                begin
                    drain_reg <= drain_reg - 4'd1;
                end
                else
                begin
                    stat_pend_reg <= 1'b0;
                end
            end
            if (pop)
            begin
                pass_pend_reg <= head.c.op == OP_PASS;
                stat_pend_reg <= head.last;
                if (head.c.op == OP_NUMERIC)
                begin
                    if (head.c.close)
                    begin
                        afill_reg <= '0;
                        drain_reg <= head.c.long_arg ? 4'd8 : 4'd4;
                    end
                    else
                    begin
                        afill_reg <= afill_reg + 3'd1;
                    end
                end
                if (head.last)
                begin
                    afill_reg <= '0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/osc_packet_validator.sv =====
// top level of the osc packet validator: front parser, command queue, back end
// depends on opv_pkg, opv_stream_if, opv_front, opv_back
`default_nettype none
// Takes one packet byte per cycle, with a last-byte flag, and emits each byte
// tagged with its region; numeric arguments come out byte-reversed once complete,
// and a status item closes every packet. Input is taken at one byte per cycle
// while the command queue holds fewer than three entries; a passed byte leaves as one
// output item and a complete numeric argument as four or eight, and the queue absorbs
// incoming bytes while these drain.
module osc_packet_validator
    import opv_pkg::*;
#(
    parameter int MAX_TAGS = MAX_TAGS_DEF,
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    opv_stream_if.sink   in_ch,
    opv_stream_if.source out_ch
);
    logic cmd_valid;
    logic cmd_room;
    cmd_t cmd;

    opv_front #(.MAX_TAGS(MAX_TAGS), .MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_data(in_ch.data[7:0]), .in_last(in_ch.data[8]),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_room(cmd_room)
    );

    opv_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_last(in_ch.data[8]), .cmd_room(cmd_room),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_byte(out_ch.data[7:0]), .region(out_ch.data[10:8]),
        .status(out_ch.data[12:11]), .final_res(out_ch.data[13])
    );
endmodule
`default_nettype wire

// ===== rtl/opv_checker.sv =====
// port-level checks for the osc packet validator, bound to the top level
// depends on opv_pkg
`default_nettype none
module opv_checker
    import opv_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [13:0] out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item dropped while stalled");
    a_final_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data[13] |-> out_data[10:8] == RG_STATUS)
        else $error("final item without status region");
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data[13] |-> out_data[12:11] == 2'd0 && out_data[10:8] != RG_STATUS)
        else $error("status on a data item");
endmodule

bind osc_packet_validator opv_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
